@@ sv/can_broadcast_signal_decoder_unit_defines.svh @@
// assertion macros used by the decoder back end
`ifndef CAN_BROADCAST_SIGNAL_DECODER_UNIT_DEFINES_SVH
`define CAN_BROADCAST_SIGNAL_DECODER_UNIT_DEFINES_SVH

// clocked check, off while reset is held
`define CBSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define CBSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/cbsd_pkg.sv @@
// package: types, constants and signal tables of the can broadcast decoder
`timescale 1ns / 1ps
`default_nettype none
package cbsd_pkg;

  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int PAYLOAD_W = 64;
  localparam int CH_W      = 5;
  localparam int RAW_W     = 16;
  localparam int SCALE_W   = 2;
  localparam int IDX_W     = 2;
  localparam int WSEL_W    = 2;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [ID_W-1:0] ID_520 = 11'h520;
  localparam logic [ID_W-1:0] ID_521 = 11'h521;
  localparam logic [ID_W-1:0] ID_522 = 11'h522;
  localparam logic [ID_W-1:0] ID_530 = 11'h530;
  localparam logic [ID_W-1:0] ID_531 = 11'h531;
  localparam logic [ID_W-1:0] ID_532 = 11'h532;
  localparam logic [ID_W-1:0] ID_536 = 11'h536;
  localparam logic [ID_W-1:0] ID_537 = 11'h537;
  localparam logic [ID_W-1:0] ID_540 = 11'h540;

  localparam logic [SCALE_W-1:0] SCALE_ONE        = 2'd0;
  localparam logic [SCALE_W-1:0] SCALE_TENTH      = 2'd1;
  localparam logic [SCALE_W-1:0] SCALE_HUNDREDTH  = 2'd2;
  localparam logic [SCALE_W-1:0] SCALE_THOUSANDTH = 2'd3;

  localparam logic [WSEL_W-1:0] WORD_B0 = 2'd0;
  localparam logic [WSEL_W-1:0] WORD_B2 = 2'd1;
  localparam logic [WSEL_W-1:0] WORD_B4 = 2'd2;
  localparam logic [WSEL_W-1:0] WORD_B6 = 2'd3;

  localparam logic [CH_W-1:0] LAST_CH = 5'd23;

  typedef struct packed {
    logic              hit;
    logic [CH_W-1:0]   first_ch;
    logic [IDX_W-1:0]  last_idx;
  } id_class_t;

  typedef struct packed {
    logic [CH_W-1:0]      first_ch;
    logic [IDX_W-1:0]     last_idx;
    logic [PAYLOAD_W-1:0] payload;
  } frame_entry_t;

  typedef struct packed {
    logic [WSEL_W-1:0]  word_sel;
    logic [SCALE_W-1:0] scale;
  } sig_info_t;

  function automatic id_class_t classify_id(input logic [ID_W-1:0] id);
    id_class_t c;
    c = '0;
    c.hit = 1'b1;
    case (id)
      ID_520: begin c.first_ch = 5'd0;  c.last_idx = 2'd3; end
      ID_521: begin c.first_ch = 5'd4;  c.last_idx = 2'd1; end
      ID_522: begin c.first_ch = 5'd6;  c.last_idx = 2'd2; end
      ID_530: begin c.first_ch = 5'd9;  c.last_idx = 2'd2; end
      ID_531: begin c.first_ch = 5'd12; c.last_idx = 2'd1; end
      ID_532: begin c.first_ch = 5'd14; c.last_idx = 2'd2; end
      ID_536: begin c.first_ch = 5'd17; c.last_idx = 2'd2; end
      ID_537: begin c.first_ch = 5'd20; c.last_idx = 2'd1; end
      ID_540: begin c.first_ch = 5'd22; c.last_idx = 2'd1; end
      default: begin c = '0; end
    endcase
    return c;
  endfunction

  function automatic sig_info_t sig_info(input logic [CH_W-1:0] ch);
    sig_info_t s;
    case (ch)
      5'd0:    s = '{WORD_B0, SCALE_ONE};
      5'd1:    s = '{WORD_B2, SCALE_TENTH};
      5'd2:    s = '{WORD_B4, SCALE_TENTH};
      5'd3:    s = '{WORD_B6, SCALE_THOUSANDTH};
      5'd4:    s = '{WORD_B0, SCALE_THOUSANDTH};
      5'd5:    s = '{WORD_B4, SCALE_TENTH};
      5'd6:    s = '{WORD_B0, SCALE_THOUSANDTH};
      5'd7:    s = '{WORD_B2, SCALE_TENTH};
      5'd8:    s = '{WORD_B6, SCALE_TENTH};
      5'd9:    s = '{WORD_B0, SCALE_HUNDREDTH};
      5'd10:   s = '{WORD_B4, SCALE_TENTH};
      5'd11:   s = '{WORD_B6, SCALE_TENTH};
      5'd12:   s = '{WORD_B2, SCALE_TENTH};
      5'd13:   s = '{WORD_B6, SCALE_ONE};
      5'd14:   s = '{WORD_B0, SCALE_ONE};
      5'd15:   s = '{WORD_B2, SCALE_ONE};
      5'd16:   s = '{WORD_B4, SCALE_ONE};
      5'd17:   s = '{WORD_B0, SCALE_ONE};
      5'd18:   s = '{WORD_B4, SCALE_THOUSANDTH};
      5'd19:   s = '{WORD_B6, SCALE_TENTH};
      5'd20:   s = '{WORD_B0, SCALE_THOUSANDTH};
      5'd21:   s = '{WORD_B4, SCALE_THOUSANDTH};
      5'd22:   s = '{WORD_B4, SCALE_TENTH};
      5'd23:   s = '{WORD_B6, SCALE_TENTH};
      default: s = '{WORD_B0, SCALE_ONE};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

@@ sv/can_broadcast_signal_decoder_unit.sv @@
// top level of the can broadcast signal decoder
//
//  channel   handshake     payload
//  input     push / full   in_frame_id, in_length_code, in_remote_request, in_payload
//  result    empty / pop   out_channel, out_raw_value, out_scale_code, out_last
//
// a matching frame yields 2 to 4 results, one per cycle while pop keeps up
// a frame may be pushed every cycle until the 4-entry frame queue fills
// remote, short or unknown frames are taken and dropped with no result
// sustained rate is set by the back end stepper: one result per cycle while popped
// reset is synchronous active low and empties queue and result register
`timescale 1ns / 1ps
`default_nettype none
module can_broadcast_signal_decoder_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [cbsd_pkg::ID_W-1:0]      in_frame_id,
  input  wire logic [cbsd_pkg::LEN_W-1:0]     in_length_code,
  input  wire logic                           in_remote_request,
  input  wire logic [cbsd_pkg::PAYLOAD_W-1:0] in_payload,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [cbsd_pkg::CH_W-1:0]           out_channel,
  output logic signed [cbsd_pkg::RAW_W-1:0]   out_raw_value,
  output logic [cbsd_pkg::SCALE_W-1:0]        out_scale_code,
  output logic                                out_last
);
  import cbsd_pkg::*;

  logic         q_full;
  logic         q_push;
  frame_entry_t q_wdata;
  logic         q_pop;
  frame_entry_t q_head;
  logic         q_valid;

  cbsd_front u_front (
    .push              (push),
    .full              (full),
    .in_frame_id       (in_frame_id),
    .in_length_code    (in_length_code),
    .in_remote_request (in_remote_request),
    .in_payload        (in_payload),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_wdata           (q_wdata)
  );

  cbsd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_valid (q_valid)
  );

  cbsd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .head_valid     (q_valid),
    .head_pop       (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_channel    (out_channel),
    .out_raw_value  (out_raw_value),
    .out_scale_code (out_scale_code),
    .out_last       (out_last)
  );

endmodule
`default_nettype wire

@@ sv/cbsd_front.sv @@
// front end: filters remote, short and unknown frames and looks up the identifier
`timescale 1ns / 1ps
`default_nettype none
module cbsd_front (
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [cbsd_pkg::ID_W-1:0]      in_frame_id,
  input  wire logic [cbsd_pkg::LEN_W-1:0]     in_length_code,
  input  wire logic                           in_remote_request,
  input  wire logic [cbsd_pkg::PAYLOAD_W-1:0] in_payload,
  input  wire logic                           q_full,
  output logic                                q_push,
  output cbsd_pkg::frame_entry_t              q_wdata
);
  import cbsd_pkg::*;

  id_class_t cls;
  logic      keep;

  always_comb begin
    cls  = classify_id(in_frame_id);
    // length codes of 8 and up count as a full frame
    keep = cls.hit && !in_remote_request && in_length_code[LEN_W-1];
  end

  assign full             = q_full;
  assign q_push           = push && !q_full && keep;
  assign q_wdata.first_ch = cls.first_ch;
  assign q_wdata.last_idx = cls.last_idx;
  assign q_wdata.payload  = in_payload;

endmodule
`default_nettype wire

@@ sv/cbsd_queue.sv @@
// four-entry frame queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module cbsd_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  cbsd_pkg::frame_entry_t      wr_data,
  output logic                        q_full,
  input  wire logic                   rd_en,
  output cbsd_pkg::frame_entry_t      rd_data,
  output logic                        q_valid
);
  import cbsd_pkg::*;

  frame_entry_t         slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, wptr_nxt;
  logic [Q_PTR_W-1:0]   rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_wr, do_rd;

  assign q_full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign rd_data = slot_r[rptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

@@ sv/cbsd_back.sv @@
// back end: steps through the signals of the head frame into the result register
`timescale 1ns / 1ps
`default_nettype none
`include "can_broadcast_signal_decoder_unit_defines.svh"
module cbsd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  cbsd_pkg::frame_entry_t             head,
  input  wire logic                          head_valid,
  output logic                               head_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [cbsd_pkg::CH_W-1:0]          out_channel,
  output logic signed [cbsd_pkg::RAW_W-1:0]  out_raw_value,
  output logic [cbsd_pkg::SCALE_W-1:0]       out_scale_code,
  output logic                               out_last
);
  import cbsd_pkg::*;

  logic [IDX_W-1:0]   sub_r, sub_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [CH_W-1:0]    ch_r;
  logic [RAW_W-1:0]   raw_r;
  logic [SCALE_W-1:0] scale_r;
  logic               last_r;

  logic               advance;
  logic               at_end;
  logic [CH_W-1:0]    cur_ch;
  sig_info_t          info;
  logic [RAW_W-1:0]   word;

  always_comb begin
    advance = head_valid && (!ovalid_r || pop);
    at_end  = (sub_r == head.last_idx);
    cur_ch  = head.first_ch + CH_W'(sub_r);
    info    = sig_info(cur_ch);
    case (info.word_sel)
      WORD_B0: word = head.payload[15:0];
      WORD_B2: word = head.payload[31:16];
      WORD_B4: word = head.payload[47:32];
      WORD_B6: word = head.payload[63:48];
      default: word = head.payload[15:0];
    endcase
    head_pop   = advance && at_end;
    sub_nxt    = sub_r;
    if (advance) begin
      sub_nxt = at_end ? '0 : sub_r + 1'b1;
    end
    ovalid_nxt = ovalid_r;
    if (advance) begin
      ovalid_nxt = 1'b1;
    end else if (pop) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      sub_r    <= sub_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ch_r    <= cur_ch;
      raw_r   <= word;
      scale_r <= info.scale;
      last_r  <= at_end;
    end
  end

  assign empty          = !ovalid_r;
  assign out_channel    = ch_r;
  assign out_raw_value  = raw_r;
  assign out_scale_code = scale_r;
  assign out_last       = last_r;

  `CBSD_ASSERT(a_ch_range, ovalid_r |-> (ch_r <= LAST_CH), "channel out of range")
  `CBSD_ASSERT(a_sub_bound, head_valid |-> (sub_r <= head.last_idx), "index past frame end")
  `CBSD_ASSERT(a_pop_marks_last, head_pop |=> (ovalid_r && last_r), "frame end not marked last")
  `CBSD_ASSERT(a_idle_index, !head_valid |-> (sub_r == '0), "index left over without frame")
  `CBSD_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> empty, "result not empty after reset")

endmodule
`default_nettype wire

@@ tb/sv/tb_can_broadcast_signal_decoder_unit.sv @@
// testbench for the can broadcast signal decoder: frames in, decoded signals checked in order
`timescale 1ns / 1ps
module tb_can_broadcast_signal_decoder_unit;
  import cbsd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [2:0]         byte_off;
    logic [SCALE_W-1:0] scale;
  } signal_row_t;

  typedef struct {
    logic [CH_W-1:0]         channel;
    logic signed [RAW_W-1:0] raw_value;
    logic [SCALE_W-1:0]      scale_code;
    logic                    last;
  } decoded_signal_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 push = 1'b0;
  logic                 full;
  logic [ID_W-1:0]      in_frame_id = '0;
  logic [LEN_W-1:0]     in_length_code = '0;
  logic                 in_remote_request = 1'b0;
  logic [PAYLOAD_W-1:0] in_payload = '0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [CH_W-1:0]      out_channel;
  logic signed [RAW_W-1:0] out_raw_value;
  logic [SCALE_W-1:0]   out_scale_code;
  logic                 out_last;

  decoded_signal_t expected_signals[$];
  int error_count = 0;
  int quiet_cycles = 0;
  bit steady_traffic = 1'b0;

  can_broadcast_signal_decoder_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_frame_id       (in_frame_id),
    .in_length_code    (in_length_code),
    .in_remote_request (in_remote_request),
    .in_payload        (in_payload),
    .empty             (empty),
    .pop               (pop),
    .out_channel       (out_channel),
    .out_raw_value     (out_raw_value),
    .out_scale_code    (out_scale_code),
    .out_last          (out_last)
  );

  always #5 clk = ~clk;

  function automatic signal_row_t signal_row(input int ch);
    signal_row_t r;
    case (ch)
      0:       r = '{ID_520, 3'd0, SCALE_ONE};
      1:       r = '{ID_520, 3'd2, SCALE_TENTH};
      2:       r = '{ID_520, 3'd4, SCALE_TENTH};
      3:       r = '{ID_520, 3'd6, SCALE_THOUSANDTH};
      4:       r = '{ID_521, 3'd0, SCALE_THOUSANDTH};
      5:       r = '{ID_521, 3'd4, SCALE_TENTH};
      6:       r = '{ID_522, 3'd0, SCALE_THOUSANDTH};
      7:       r = '{ID_522, 3'd2, SCALE_TENTH};
      8:       r = '{ID_522, 3'd6, SCALE_TENTH};
      9:       r = '{ID_530, 3'd0, SCALE_HUNDREDTH};
      10:      r = '{ID_530, 3'd4, SCALE_TENTH};
      11:      r = '{ID_530, 3'd6, SCALE_TENTH};
      12:      r = '{ID_531, 3'd2, SCALE_TENTH};
      13:      r = '{ID_531, 3'd6, SCALE_ONE};
      14:      r = '{ID_532, 3'd0, SCALE_ONE};
      15:      r = '{ID_532, 3'd2, SCALE_ONE};
      16:      r = '{ID_532, 3'd4, SCALE_ONE};
      17:      r = '{ID_536, 3'd0, SCALE_ONE};
      18:      r = '{ID_536, 3'd4, SCALE_THOUSANDTH};
      19:      r = '{ID_536, 3'd6, SCALE_TENTH};
      20:      r = '{ID_537, 3'd0, SCALE_THOUSANDTH};
      21:      r = '{ID_537, 3'd4, SCALE_THOUSANDTH};
      22:      r = '{ID_540, 3'd4, SCALE_TENTH};
      default: r = '{ID_540, 3'd6, SCALE_TENTH};
    endcase
    return r;
  endfunction

  function automatic logic [ID_W-1:0] known_id(input int k);
    case (k)
      0:       return ID_520;
      1:       return ID_521;
      2:       return ID_522;
      3:       return ID_530;
      4:       return ID_531;
      5:       return ID_532;
      6:       return ID_536;
      7:       return ID_537;
      default: return ID_540;
    endcase
  endfunction

  // queues the signals one accepted frame decodes into, returns how many
  function automatic int predict_signals(input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len,
                                         input logic rtr,
                                         input logic [PAYLOAD_W-1:0] payload);
    signal_row_t row;
    decoded_signal_t sig;
    int n;
    n = 0;
    if (rtr || len < 4'd8) return 0;
    for (int ch = 0; ch < 24; ch++) begin
      row = signal_row(ch);
      if (row.id == id && n < 4) begin
        sig.channel = CH_W'(ch);
        sig.raw_value = payload[row.byte_off * 8 +: 16];
        sig.scale_code = row.scale;
        sig.last = 1'b0;
        expected_signals.push_back(sig);
        n++;
      end
    end
    if (n > 0) expected_signals[expected_signals.size() - 1].last = 1'b1;
    return n;
  endfunction

  task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                            input logic rtr, input logic [PAYLOAD_W-1:0] payload,
                            output int produced);
    while (!steady_traffic && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_frame_id <= id;
    in_length_code <= len;
    in_remote_request <= rtr;
    in_payload <= payload;
    do @(posedge clk); while (full);
    produced = predict_signals(id, len, rtr, payload);
  endtask

  task automatic send_random_frame(input bit well_formed, output int produced);
    logic [ID_W-1:0] id;
    logic [LEN_W-1:0] len;
    logic rtr;
    if (well_formed) begin
      id = known_id($urandom_range(8));
      len = $urandom_range(1) ? 4'd8 : LEN_W'($urandom_range(8, 15));
      rtr = 1'b0;
    end else begin
      id = $urandom_range(3) == 0 ? known_id($urandom_range(8)) : ID_W'($urandom_range(2047));
      len = LEN_W'($urandom_range(15));
      rtr = 1'($urandom_range(1));
    end
    send_frame(id, len, rtr, {$urandom, $urandom}, produced);
  endtask

  task automatic test_known_ids();
    int n;
    for (int k = 0; k < 9; k++)
      send_frame(known_id(k), 4'd8, 1'b0, {$urandom, $urandom}, n);
  endtask

  task automatic test_word_extremes();
    int n;
    send_frame(ID_520, 4'd8, 1'b0, 64'h0, n);
    send_frame(ID_520, 4'd8, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, n);
    send_frame(ID_520, 4'd8, 1'b0, 64'h8000_7FFF_8000_7FFF, n);
    send_frame(ID_520, 4'd8, 1'b0, 64'h7FFF_8000_7FFF_8000, n);
    send_frame(ID_532, 4'd8, 1'b0, 64'h0123_4567_89AB_CDEF, n);
  endtask

  task automatic test_ignored_frames();
    int n;
    send_frame(ID_520, 4'd8, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, n);
    send_frame(ID_540, 4'd15, 1'b1, {$urandom, $urandom}, n);
    send_frame(ID_521, 4'd7, 1'b0, {$urandom, $urandom}, n);
    send_frame(ID_537, 4'd0, 1'b0, {$urandom, $urandom}, n);
    send_frame(11'h000, 4'd8, 1'b0, {$urandom, $urandom}, n);
    send_frame(11'h7FF, 4'd15, 1'b0, {$urandom, $urandom}, n);
    send_frame(11'h523, 4'd8, 1'b0, {$urandom, $urandom}, n);
    send_frame(11'h53F, 4'd8, 1'b0, {$urandom, $urandom}, n);
  endtask

  task automatic test_long_length();
    int n;
    send_frame(ID_530, 4'd9, 1'b0, {$urandom, $urandom}, n);
    send_frame(ID_536, 4'd15, 1'b0, {$urandom, $urandom}, n);
    send_frame(ID_531, 4'd12, 1'b0, {$urandom, $urandom}, n);
  endtask

  task automatic test_back_to_back(input int frames);
    int n;
    int sent;
    sent = 0;
    steady_traffic = 1'b1;
    while (sent < frames) begin
      send_random_frame($urandom_range(9) != 0, n);
      sent++;
    end
    steady_traffic = 1'b0;
  endtask

  task automatic test_random_traffic(input int frames);
    int n;
    int sent;
    sent = 0;
    while (sent < frames) begin
      send_random_frame($urandom_range(99) < 75, n);
      sent++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= steady_traffic || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk) begin : check_results
    decoded_signal_t want;
    if (rst_n && pop && !empty) begin
      if (expected_signals.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual channel %0d raw %0d",
                 $time, out_channel, out_raw_value);
        error_count++;
      end else begin
        want = expected_signals.pop_front();
        if (out_channel !== want.channel) begin
          $display("%0t: channel mismatch: expected %0d, actual %0d",
                   $time, want.channel, out_channel);
          error_count++;
        end
        if (out_raw_value !== want.raw_value) begin
          $display("%0t: raw_value mismatch on channel %0d: expected %0d, actual %0d",
                   $time, want.channel, want.raw_value, out_raw_value);
          error_count++;
        end
        if (out_scale_code !== want.scale_code) begin
          $display("%0t: scale_code mismatch on channel %0d: expected %0d, actual %0d",
                   $time, want.channel, want.scale_code, out_scale_code);
          error_count++;
        end
        if (out_last !== want.last) begin
          $display("%0t: last mismatch on channel %0d: expected %0b, actual %0b",
                   $time, want.channel, want.last, out_last);
          error_count++;
        end
      end
    end
  end

  // ends the run when no transaction moves on either side for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_known_ids();
    test_word_extremes();
    test_ignored_frames();
    test_long_length();
    test_back_to_back(120);
    test_random_traffic(330);
    push <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
